@@ rtl/core/sqd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqd_pkg
// Types and constants for the shortest-queue dispatcher.
// ----------------------------------------------------------------------------
package sqd_pkg;

  localparam int SERVERS     = 3;
  localparam int QUEUE_DEPTH = 64;
  localparam int TAG_BITS    = 16;

  localparam int SRV_W  = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LOAD_W = CNT_W + 1;
  localparam int MEM_DEPTH = SERVERS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  localparam logic [1:0] REQ_ARRIVE = 2'd0;
  localparam logic [1:0] REQ_TAKE   = 2'd1;
  localparam logic [1:0] REQ_DONE   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  server;
    logic [15:0] client_tag;
  } sqd_in_t;

  typedef struct packed {
    logic [1:0]  server_out;
    logic [15:0] tag_out;
    logic [1:0]  status;
  } sqd_out_t;

endpackage
`default_nettype wire

@@ rtl/core/shortest_queue_dispatcher_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shortest_queue_dispatcher_unit
// Join-shortest-queue dispatcher: per-server tag queues in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry requests: arrival (enqueue client_tag on
//   the least loaded server, load = queue count + busy), take (pop the named
//   server's head, mark it busy) and done (clear busy). Every request yields
//   one result beat on out_valid/out_ready/out_data.
//   From acceptance a request passes through the memory stage, which holds
//   the synchronous read of the tag memory, and then the output register.
//   One request per cycle while not stalled; head, tail, count and busy state
//   are updated at acceptance, so the next request sees them at once. A
//   tag written by an arrival is in memory before any later take reads it.
//   Reset clears all queue pointers, counts and busy flags; the tag memory
//   is not cleared, since only written entries are ever read.
//   When the receiver stalls, the output register and the memory stage
//   hold their results and in_ready drops once both are full.
// ----------------------------------------------------------------------------
module shortest_queue_dispatcher_unit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sqd_pkg::sqd_in_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sqd_pkg::sqd_out_t    out_data
);

  // per-server control state
  logic [sqd_pkg::IDX_W-1:0] head_r [sqd_pkg::SERVERS];
  logic [sqd_pkg::IDX_W-1:0] head_nxt [sqd_pkg::SERVERS];
  logic [sqd_pkg::IDX_W-1:0] tail_r [sqd_pkg::SERVERS];
  logic [sqd_pkg::IDX_W-1:0] tail_nxt [sqd_pkg::SERVERS];
  logic [sqd_pkg::CNT_W-1:0] cnt_r [sqd_pkg::SERVERS];
  logic [sqd_pkg::CNT_W-1:0] cnt_nxt [sqd_pkg::SERVERS];
  logic [sqd_pkg::SERVERS-1:0] busy_r, busy_nxt;

  // tag memory
  logic [sqd_pkg::TAG_BITS-1:0] mem [sqd_pkg::MEM_DEPTH];
  logic [sqd_pkg::TAG_BITS-1:0] rdata_r;
  logic                         mem_we, mem_re;
  logic [sqd_pkg::ADDR_W-1:0]   mem_addr;

  // memory stage
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_take_r, s1_take_nxt;
  logic [1:0] s1_srv_r, s1_srv_nxt;
  logic [1:0] s1_status_r, s1_status_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  sqd_pkg::sqd_out_t out_data_r, out_data_nxt;

  logic s1_move, in_acc;

  // request decode
  logic [sqd_pkg::SRV_W-1:0]  best;
  logic [sqd_pkg::LOAD_W-1:0] min_load, load_i;
  logic [sqd_pkg::SRV_W-1:0]  srv_idx;
  logic                       srv_ok;
  logic [sqd_pkg::IDX_W-1:0]  idx;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign in_acc   = in_valid && in_ready;

  assign srv_idx = sqd_pkg::SRV_W'(in_data.server);
  assign srv_ok  = {30'd0, in_data.server} < 32'(sqd_pkg::SERVERS);

  // least loaded server, ties to lowest index
  always_comb begin
    best     = '0;
    min_load = sqd_pkg::LOAD_W'(cnt_r[0]) + sqd_pkg::LOAD_W'(busy_r[0]);
    for (int i = 1; i < sqd_pkg::SERVERS; i++) begin
      load_i = sqd_pkg::LOAD_W'(cnt_r[i]) + sqd_pkg::LOAD_W'(busy_r[i]);
      if (load_i < min_load) begin
        best     = sqd_pkg::SRV_W'(i);
        min_load = load_i;
      end
    end
  end

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    busy_nxt      = busy_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = '0;
    idx           = '0;
    s1_take_nxt   = s1_take_r;
    s1_srv_nxt    = s1_srv_r;
    s1_status_nxt = s1_status_r;
    s1_valid_nxt  = s1_valid_r && !s1_move;
    if (in_acc) begin
      s1_valid_nxt  = 1'b1;
      s1_take_nxt   = 1'b0;
      s1_srv_nxt    = in_data.server;
      s1_status_nxt = sqd_pkg::ST_OK;
      unique case (in_data.req_type)
        sqd_pkg::REQ_ARRIVE: begin
          s1_srv_nxt = 2'(best);
          if (cnt_r[best] == sqd_pkg::CNT_W'(sqd_pkg::QUEUE_DEPTH)) begin
            s1_status_nxt = sqd_pkg::ST_DROPPED;
          end else begin
            idx      = tail_r[best];
            mem_we   = 1'b1;
            mem_addr = sqd_pkg::ADDR_W'(best * sqd_pkg::QUEUE_DEPTH)
                       + sqd_pkg::ADDR_W'(idx);
            tail_nxt[best] = (idx == sqd_pkg::IDX_W'(sqd_pkg::QUEUE_DEPTH - 1))
                             ? '0 : idx + 1'b1;
            cnt_nxt[best]  = cnt_r[best] + 1'b1;
          end
        end
        sqd_pkg::REQ_TAKE: begin
          if (!srv_ok || cnt_r[srv_idx] == '0) begin
            s1_status_nxt = sqd_pkg::ST_EMPTY;
          end else begin
            idx         = head_r[srv_idx];
            mem_re      = 1'b1;
            s1_take_nxt = 1'b1;
            mem_addr    = sqd_pkg::ADDR_W'(srv_idx * sqd_pkg::QUEUE_DEPTH)
                          + sqd_pkg::ADDR_W'(idx);
            head_nxt[srv_idx] = (idx == sqd_pkg::IDX_W'(sqd_pkg::QUEUE_DEPTH - 1))
                                ? '0 : idx + 1'b1;
            cnt_nxt[srv_idx]  = cnt_r[srv_idx] - 1'b1;
            busy_nxt[srv_idx] = 1'b1;
          end
        end
        sqd_pkg::REQ_DONE: begin
          if (srv_ok) begin
            busy_nxt[srv_idx] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (s1_move) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.server_out = s1_srv_r;
      out_data_nxt.tag_out  = s1_take_r ? 16'(rdata_r) : 16'd0;
      out_data_nxt.status   = s1_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_data.client_tag[sqd_pkg::TAG_BITS-1:0];
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sqd_pkg::SERVERS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      busy_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_take_r   <= s1_take_nxt;
    s1_srv_r    <= s1_srv_nxt;
    s1_status_r <= s1_status_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
